@@ hw/rtl/acsc_pkg.sv @@
// Alarm clock setting controller package: payload structs, mode and command codes,
// configuration register indexes and the counter, mode code and BCD step helpers.
// No dependencies.
package acsc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_BLINK_HALF = 2'd2;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned BcdW = 14;

  // Reset values of the configuration registers
  localparam logic [15:0] LONG_PRESS_RST = 16'd30;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd300;
  localparam logic [7:0] BLINK_HALF_RST = 8'd5;

  // Operating mode, one-hot
  typedef enum logic [5:0] {
    MODE_UNSET  = 6'b000001,
    MODE_MIN    = 6'b000010,
    MODE_HOUR   = 6'b000100,
    MODE_NORMAL = 6'b001000,
    MODE_AMIN   = 6'b010000,
    MODE_AHOUR  = 6'b100000
  } mode_e;

  // Mode codes as reported on the result
  localparam logic [2:0] MODE_CODE_UNSET = 3'd0;
  localparam logic [2:0] MODE_CODE_MIN = 3'd1;
  localparam logic [2:0] MODE_CODE_HOUR = 3'd2;
  localparam logic [2:0] MODE_CODE_NORMAL = 3'd3;
  localparam logic [2:0] MODE_CODE_AMIN = 3'd4;
  localparam logic [2:0] MODE_CODE_AHOUR = 3'd5;

  // Clock commands
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_SET_TIME  = 3'd1,
    CMD_SET_ALARM = 3'd2,
    CMD_SNOOZE    = 3'd3,
    CMD_ALARM_ON  = 3'd4,
    CMD_ALARM_OFF = 3'd5
  } cmd_e;

  // Display masks
  localparam logic [3:0] FLASH_ALL = 4'b1111;
  localparam logic [3:0] FLASH_MINUTES = 4'b1100;
  localparam logic [3:0] FLASH_HOURS = 4'b0011;
  localparam logic [3:0] DOTS_ALL = 4'b1111;

  typedef struct packed {
    logic             key_f1;
    logic             key_f2;
    logic             key_down;
    logic             key_up;
    logic             key_accept;
    logic             key_cancel;
    logic             alarm_fired;
    logic             clock_valid;
    logic [BcdW-1:0]  clock_time_bcd;
    logic [BcdW-1:0]  alarm_time_bcd;
    logic             alarm_is_enabled;
  } in_t;

  typedef struct packed {
    logic [2:0]       command;
    logic [BcdW-1:0]  command_time_bcd;
    logic             buzzer_on;
    logic [BcdW-1:0]  shown_time_bcd;
    logic [3:0]       flash_mask;
    logic [3:0]       dot_mask;
    logic [2:0]       mode;
  } out_t;

  // Configuration register set
  typedef struct packed {
    logic [15:0] long_press;
    logic [15:0] idle_timeout;
    logic [7:0]  blink_half;
  } cfg_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [2:0] mode_code(input mode_e m);
    logic [2:0] c;
    c = MODE_CODE_UNSET;
    unique case (m)
      MODE_UNSET:  c = MODE_CODE_UNSET;
      MODE_MIN:    c = MODE_CODE_MIN;
      MODE_HOUR:   c = MODE_CODE_HOUR;
      MODE_NORMAL: c = MODE_CODE_NORMAL;
      MODE_AMIN:   c = MODE_CODE_AMIN;
      MODE_AHOUR:  c = MODE_CODE_AHOUR;
      default:     c = MODE_CODE_UNSET;
    endcase
    return c;
  endfunction

  // Step hh:mm BCD digits by one minute or one hour with wrap inside 00:00..23:59.
  // Digit 0 is the hour tens; each digit wraps in 4 bits.
  function automatic logic [15:0] bcd_step(input logic [15:0] v, input logic minutes,
                                           input logic up);
    logic [3:0] d0, d1, d2, d3;
    d0 = v[15:12];
    d1 = v[11:8];
    d2 = v[7:4];
    d3 = v[3:0];
    if (up) begin
      if (minutes) begin
        d3 = d3 + 4'd1;
        if (d3 > 4'd9) begin
          d3 = 4'd0;
          d2 = d2 + 4'd1;
        end
        if (d2 > 4'd5) d2 = 4'd0;
      end else begin
        d1 = d1 + 4'd1;
        if (d0 == 4'd2 && d1 > 4'd3) begin
          d0 = 4'd0;
          d1 = 4'd0;
        end else if (d1 > 4'd9) begin
          d1 = 4'd0;
          d0 = d0 + 4'd1;
        end
      end
    end else begin
      if (minutes) begin
        if (d3 == 4'd0 && d2 == 4'd0) begin
          d2 = 4'd5;
          d3 = 4'd9;
        end else if (d3 == 4'd0) begin
          d3 = 4'd9;
          d2 = d2 - 4'd1;
        end else begin
          d3 = d3 - 4'd1;
        end
      end else begin
        if (d0 == 4'd0 && d1 == 4'd0) begin
          d0 = 4'd2;
          d1 = 4'd3;
        end else if (d1 == 4'd0) begin
          d1 = 4'd9;
          d0 = d0 - 4'd1;
        end else begin
          d1 = d1 - 4'd1;
        end
      end
    end
    return {d0, d1, d2, d3};
  endfunction

endpackage

@@ hw/rtl/alarm_clock_setting_controller.sv @@
// Alarm clock setting controller top level: input register, tick logic, result register.
// Depends on acsc_pkg, acsc_cfg_regs and acsc_core.
//
// Each input transaction is one 100 ms user-interface tick and yields exactly one result
// transaction. Throughput is one tick per clock cycle while the output does not stall; a tick
// passes the input register, then the combinational tick logic, then the result register.
// The input side stays ready whenever the result register is empty or being taken,
// so a stalled output stops the flow only once both registers hold a tick. Configuration
// writes take effect on the next edge and are meant for when no tick is in flight.
module alarm_clock_setting_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [acsc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [acsc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  acsc_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output acsc_pkg::out_t                  out_data_o
);

  acsc_pkg::cfg_t cfg;
  acsc_pkg::in_t  in_q;
  logic           in_valid_q;
  acsc_pkg::out_t result;
  acsc_pkg::out_t out_q;
  logic           out_valid_q;
  logic           advance;
  logic           step;

  acsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Move a tick into the result register when that register is free or draining
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

  acsc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg),
    .item_i   (in_q),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/acsc_cfg_regs.sv @@
// Configuration register file of the alarm clock setting controller.
// Depends on acsc_pkg.
module acsc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [acsc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [acsc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output acsc_pkg::cfg_t                  cfg_o
);

  acsc_pkg::cfg_t cfg_q;

  // Decode the index and store the write; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press   <= acsc_pkg::LONG_PRESS_RST;
      cfg_q.idle_timeout <= acsc_pkg::IDLE_TIMEOUT_RST;
      cfg_q.blink_half   <= acsc_pkg::BLINK_HALF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        acsc_pkg::CFG_LONG_PRESS:   cfg_q.long_press <= cfg_wdata_i;
        acsc_pkg::CFG_IDLE_TIMEOUT: cfg_q.idle_timeout <= cfg_wdata_i;
        acsc_pkg::CFG_BLINK_HALF:   cfg_q.blink_half <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/acsc_core.sv @@
// Per-tick state machine of the alarm clock setting controller: mode, hold and idle
// counters, ringing flag, edit digits, key history and blink divider.
// Depends on acsc_pkg.
module acsc_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  acsc_pkg::cfg_t  cfg_i,
  input  acsc_pkg::in_t   item_i,
  output acsc_pkg::out_t  result_o
);

  acsc_pkg::mode_e mode_q, mode_d, edit_mode;
  logic [15:0]     f1_cnt_q, f1_cnt_d;
  logic [15:0]     f2_cnt_q, f2_cnt_d;
  logic [15:0]     idle_cnt_q, idle_cnt_d;
  logic            ring_q, ring_d;
  logic [15:0]     edit_q, edit_d;
  logic [3:0]      keys_q, keys_d;
  logic [7:0]      blink_cnt_q, blink_cnt_d;
  logic            blink_q, blink_d;

  logic [3:0]      edges;
  logic            e_dn, e_up, e_ac, e_ca;
  logic            idle_mode, minutes, time_edit;
  logic            clk_valid, alarm_en;
  logic [acsc_pkg::BcdW-1:0] now_bcd, shown;
  acsc_pkg::cmd_e  cmd;
  logic [acsc_pkg::BcdW-1:0] cmd_t;
  logic [3:0]      flash, dots;

  // Key edges: bit0 down, bit1 up, bit2 accept, bit3 cancel
  assign keys_d = {item_i.key_cancel, item_i.key_accept, item_i.key_up, item_i.key_down};
  assign edges  = keys_d & ~keys_q;
  assign e_dn   = edges[0];
  assign e_up   = edges[1];
  assign e_ac   = edges[2];
  assign e_ca   = edges[3];

  // Next state and result for one tick
  always_comb begin
    mode_d      = mode_q;
    edit_mode   = mode_q;
    f1_cnt_d    = f1_cnt_q;
    f2_cnt_d    = f2_cnt_q;
    idle_cnt_d  = idle_cnt_q;
    ring_d      = ring_q;
    edit_d      = edit_q;
    cmd         = acsc_pkg::CMD_NONE;
    cmd_t       = '0;
    clk_valid   = item_i.clock_valid;
    now_bcd     = item_i.clock_time_bcd;
    alarm_en    = item_i.alarm_is_enabled;
    idle_mode   = 1'b0;
    minutes     = 1'b0;
    time_edit   = 1'b0;

    if (ring_q) begin
      // Ringing: accept snoozes, cancel silences, nothing else
      if (e_ac) begin
        cmd    = acsc_pkg::CMD_SNOOZE;
        ring_d = 1'b0;
      end
      if (e_ca) ring_d = 1'b0;
    end else begin
      idle_mode = (mode_q == acsc_pkg::MODE_NORMAL) || (mode_q == acsc_pkg::MODE_UNSET);
      if (idle_mode) begin
        if (e_ac) cmd = acsc_pkg::CMD_ALARM_ON;
        if (e_ca) cmd = acsc_pkg::CMD_ALARM_OFF;
      end

      // F1 long press enters time setting
      if (item_i.key_f1 && idle_mode) begin
        f1_cnt_d = acsc_pkg::sat_inc16(f1_cnt_q);
        if (f1_cnt_d >= cfg_i.long_press) begin
          mode_d     = acsc_pkg::MODE_MIN;
          f1_cnt_d   = '0;
          idle_cnt_d = '0;
          edit_d     = item_i.clock_valid ? {2'b00, item_i.clock_time_bcd} : 16'h0000;
        end
      end else begin
        f1_cnt_d = '0;
      end

      // F2 long press enters alarm setting, only from normal mode
      if (item_i.key_f2 && mode_d == acsc_pkg::MODE_NORMAL) begin
        f2_cnt_d = acsc_pkg::sat_inc16(f2_cnt_q);
        if (f2_cnt_d >= cfg_i.long_press) begin
          mode_d     = acsc_pkg::MODE_AMIN;
          f2_cnt_d   = '0;
          idle_cnt_d = '0;
          edit_d     = {2'b00, item_i.alarm_time_bcd};
        end
      end else begin
        f2_cnt_d = '0;
      end

      // Setting modes: step digits, advance or commit, abandon on cancel or timeout
      edit_mode = mode_d;
      if (edit_mode != acsc_pkg::MODE_NORMAL && edit_mode != acsc_pkg::MODE_UNSET) begin
        minutes    = (edit_mode == acsc_pkg::MODE_MIN) || (edit_mode == acsc_pkg::MODE_AMIN);
        time_edit  = (edit_mode == acsc_pkg::MODE_MIN) || (edit_mode == acsc_pkg::MODE_HOUR);
        idle_cnt_d = acsc_pkg::sat_inc16(idle_cnt_d);
        if (e_up) begin
          edit_d     = acsc_pkg::bcd_step(edit_d, minutes, 1'b1);
          idle_cnt_d = '0;
        end
        if (e_dn) begin
          edit_d     = acsc_pkg::bcd_step(edit_d, minutes, 1'b0);
          idle_cnt_d = '0;
        end
        if (e_ac) begin
          unique case (edit_mode)
            acsc_pkg::MODE_MIN:  mode_d = acsc_pkg::MODE_HOUR;
            acsc_pkg::MODE_AMIN: mode_d = acsc_pkg::MODE_AHOUR;
            acsc_pkg::MODE_HOUR: begin
              cmd       = acsc_pkg::CMD_SET_TIME;
              cmd_t     = edit_d[acsc_pkg::BcdW-1:0];
              clk_valid = 1'b1;
              now_bcd   = edit_d[acsc_pkg::BcdW-1:0];
              mode_d    = acsc_pkg::MODE_NORMAL;
            end
            default: begin
              cmd    = acsc_pkg::CMD_SET_ALARM;
              cmd_t  = edit_d[acsc_pkg::BcdW-1:0];
              mode_d = acsc_pkg::MODE_NORMAL;
            end
          endcase
          idle_cnt_d = '0;
        end
        if (e_ca || idle_cnt_d >= cfg_i.idle_timeout) begin
          if (time_edit) begin
            mode_d = clk_valid ? acsc_pkg::MODE_NORMAL : acsc_pkg::MODE_UNSET;
          end else begin
            mode_d = acsc_pkg::MODE_NORMAL;
          end
        end
      end
    end

    if (item_i.alarm_fired) ring_d = 1'b1;

    if (cmd == acsc_pkg::CMD_ALARM_ON) alarm_en = 1'b1;
    if (cmd == acsc_pkg::CMD_ALARM_OFF) alarm_en = 1'b0;
  end

  // Seconds dot blink divider
  always_comb begin
    blink_cnt_d = acsc_pkg::sat_inc8(blink_cnt_q);
    blink_d     = blink_q;
    if (blink_cnt_d >= cfg_i.blink_half) begin
      blink_cnt_d = '0;
      blink_d     = ~blink_q;
    end
  end

  // Display outputs from the mode after this tick
  always_comb begin
    flash = '0;
    dots  = '0;
    shown = edit_d[acsc_pkg::BcdW-1:0];
    unique case (mode_d)
      acsc_pkg::MODE_UNSET, acsc_pkg::MODE_NORMAL: begin
        flash = (mode_d == acsc_pkg::MODE_UNSET) ? acsc_pkg::FLASH_ALL : 4'b0000;
        shown = clk_valid ? now_bcd : '0;
        dots  = {2'b00, blink_d, alarm_en};
      end
      acsc_pkg::MODE_MIN:   flash = acsc_pkg::FLASH_MINUTES;
      acsc_pkg::MODE_HOUR:  flash = acsc_pkg::FLASH_HOURS;
      acsc_pkg::MODE_AMIN: begin
        flash = acsc_pkg::FLASH_MINUTES;
        dots  = acsc_pkg::DOTS_ALL;
      end
      acsc_pkg::MODE_AHOUR: begin
        flash = acsc_pkg::FLASH_HOURS;
        dots  = acsc_pkg::DOTS_ALL;
      end
      default: ;
    endcase
  end

  assign result_o.command          = cmd;
  assign result_o.command_time_bcd = cmd_t;
  assign result_o.buzzer_on        = ring_d;
  assign result_o.shown_time_bcd   = shown;
  assign result_o.flash_mask       = flash;
  assign result_o.dot_mask         = dots;
  assign result_o.mode             = acsc_pkg::mode_code(mode_d);

  // Commit the tick's state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= acsc_pkg::MODE_UNSET;
      f1_cnt_q    <= '0;
      f2_cnt_q    <= '0;
      idle_cnt_q  <= '0;
      ring_q      <= 1'b0;
      edit_q      <= '0;
      keys_q      <= '0;
      blink_cnt_q <= '0;
      blink_q     <= 1'b0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      f1_cnt_q    <= f1_cnt_d;
      f2_cnt_q    <= f2_cnt_d;
      idle_cnt_q  <= idle_cnt_d;
      ring_q      <= ring_d;
      edit_q      <= edit_d;
      keys_q      <= keys_d;
      blink_cnt_q <= blink_cnt_d;
      blink_q     <= blink_d;
    end
  end

endmodule

@@ hw/rtl/acsc_checker.sv @@
// Port-level checks of the alarm clock setting controller, bound to the top level.
// Depends on acsc_pkg and alarm_clock_setting_controller.
module acsc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input acsc_pkg::out_t                  out_data_o
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // A taken result always frees room for a new transaction
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  // A commit leaves the block in normal mode
  a_commit_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.command == acsc_pkg::CMD_SET_TIME ||
                    out_data_o.command == acsc_pkg::CMD_SET_ALARM)
    |-> out_data_o.mode == acsc_pkg::MODE_CODE_NORMAL && out_data_o.flash_mask == 4'b0000)
    else $error("commit without return to normal mode");

  // Only commits carry a time
  a_cmd_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.command != acsc_pkg::CMD_SET_TIME &&
    out_data_o.command != acsc_pkg::CMD_SET_ALARM |-> out_data_o.command_time_bcd == '0)
    else $error("command time on a non-commit command");

  // Alarm editing lights all dots
  a_alarm_dots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.mode == acsc_pkg::MODE_CODE_AMIN ||
                    out_data_o.mode == acsc_pkg::MODE_CODE_AHOUR)
    |-> out_data_o.dot_mask == acsc_pkg::DOTS_ALL)
    else $error("alarm edit without all dots");

endmodule

bind alarm_clock_setting_controller acsc_checker u_acsc_checker (.*);

@@ dv/alarm_clock_setting_controller_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for alarm_clock_setting_controller: drives 100 ms ticks,
// predicts every result in a scoreboard class and compares. Depends on acsc_pkg and the DUT.
module alarm_clock_setting_controller_test;
  import acsc_pkg::*;

  localparam int HoldOffCycles = 80;

  // Key level bits in payload order: f1, f2, down, up, accept, cancel
  localparam logic [5:0] KEY_F1 = 6'b100000;
  localparam logic [5:0] KEY_F2 = 6'b010000;
  localparam logic [5:0] KEY_DOWN = 6'b001000;
  localparam logic [5:0] KEY_UP = 6'b000100;
  localparam logic [5:0] KEY_ACCEPT = 6'b000010;
  localparam logic [5:0] KEY_CANCEL = 6'b000001;
  localparam logic [5:0] KEYS_NONE = 6'b000000;

  // Dot bits in normal and unset modes
  localparam logic [3:0] DOT_SECONDS = 4'b0010;
  localparam logic [3:0] DOT_ALARM = 4'b0001;

  // Tick predictor and store of expected results
  class tick_scoreboard;
    logic [15:0] long_press;
    logic [15:0] idle_limit;
    logic [7:0]  blink_half;
    logic [2:0]  mode;
    logic [15:0] f1_held;
    logic [15:0] f2_held;
    logic [15:0] idle_ticks;
    logic [15:0] edit_bcd;
    logic [7:0]  blink_ticks;
    logic        blink_on;
    logic        ringing;
    logic [3:0]  last_keys;
    out_t        expected_q[$];
    int          errors;

    function new();
      long_press = LONG_PRESS_RST;
      idle_limit = IDLE_TIMEOUT_RST;
      blink_half = BLINK_HALF_RST;
      mode = MODE_CODE_UNSET;
      f1_held = '0;
      f2_held = '0;
      idle_ticks = '0;
      edit_bcd = '0;
      blink_ticks = '0;
      blink_on = 1'b0;
      ringing = 1'b0;
      last_keys = '0;
      errors = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] value);
      case (idx)
        CFG_LONG_PRESS:   long_press = value;
        CFG_IDLE_TIMEOUT: idle_limit = value;
        CFG_BLINK_HALF:   blink_half = value[7:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Step one field of hh:mm; every digit wraps in its own nibble
    function logic [15:0] step_digits(logic [15:0] v, logic minute_field, logic inc);
      logic [3:0] ht, hu, mt, mu;
      {ht, hu, mt, mu} = v;
      if (minute_field && inc) begin
        mu = mu + 4'd1;
        if (mu > 4'd9) begin
          mu = 4'd0;
          mt = mt + 4'd1;
        end
        if (mt > 4'd5) mt = 4'd0;
      end else if (minute_field) begin
        if (mu == 4'd0 && mt == 4'd0) begin
          mt = 4'd5;
          mu = 4'd9;
        end else if (mu == 4'd0) begin
          mu = 4'd9;
          mt = mt - 4'd1;
        end else begin
          mu = mu - 4'd1;
        end
      end else if (inc) begin
        hu = hu + 4'd1;
        if (ht == 4'd2 && hu > 4'd3) begin
          ht = 4'd0;
          hu = 4'd0;
        end else if (hu > 4'd9) begin
          hu = 4'd0;
          ht = ht + 4'd1;
        end
      end else begin
        if (ht == 4'd0 && hu == 4'd0) begin
          ht = 4'd2;
          hu = 4'd3;
        end else if (hu == 4'd0) begin
          hu = 4'd9;
          ht = ht - 4'd1;
        end else begin
          hu = hu - 4'd1;
        end
      end
      return {ht, hu, mt, mu};
    endfunction

    // Advance the model by one accepted tick and queue its result
    function void note_tick(in_t t);
      logic [3:0]  keys, rise;
      logic        clk_ok, at_rest, minute_field, time_field, alarm_dot;
      logic [13:0] clk_now, cmd_bcd;
      cmd_e        cmd;
      out_t        want;
      keys = {t.key_cancel, t.key_accept, t.key_up, t.key_down};
      rise = keys & ~last_keys;
      last_keys = keys;
      clk_ok = t.clock_valid;
      clk_now = t.clock_time_bcd;
      alarm_dot = t.alarm_is_enabled;
      cmd = CMD_NONE;
      cmd_bcd = '0;

      if (ringing) begin
        // ringing swallows all other key handling
        if (rise[2]) begin
          cmd = CMD_SNOOZE;
          ringing = 1'b0;
        end
        if (rise[3]) ringing = 1'b0;
      end else begin
        at_rest = (mode == MODE_CODE_NORMAL) || (mode == MODE_CODE_UNSET);
        if (at_rest && rise[2]) cmd = CMD_ALARM_ON;
        if (at_rest && rise[3]) cmd = CMD_ALARM_OFF;
        if (t.key_f1 && at_rest) begin
          f1_held = bump(f1_held);
          if (f1_held >= long_press) begin
            mode = MODE_CODE_MIN;
            f1_held = '0;
            idle_ticks = '0;
            edit_bcd = clk_ok ? {2'b00, clk_now} : 16'h0000;
          end
        end else begin
          f1_held = '0;
        end
        if (t.key_f2 && mode == MODE_CODE_NORMAL) begin
          f2_held = bump(f2_held);
          if (f2_held >= long_press) begin
            mode = MODE_CODE_AMIN;
            f2_held = '0;
            idle_ticks = '0;
            edit_bcd = {2'b00, t.alarm_time_bcd};
          end
        end else begin
          f2_held = '0;
        end
        // edit modes, including one entered on this very tick
        if (mode != MODE_CODE_NORMAL && mode != MODE_CODE_UNSET) begin
          minute_field = (mode == MODE_CODE_MIN) || (mode == MODE_CODE_AMIN);
          time_field = (mode == MODE_CODE_MIN) || (mode == MODE_CODE_HOUR);
          idle_ticks = bump(idle_ticks);
          if (rise[1]) begin
            edit_bcd = step_digits(edit_bcd, minute_field, 1'b1);
            idle_ticks = '0;
          end
          if (rise[0]) begin
            edit_bcd = step_digits(edit_bcd, minute_field, 1'b0);
            idle_ticks = '0;
          end
          if (rise[2]) begin
            case (mode)
              MODE_CODE_MIN:  mode = MODE_CODE_HOUR;
              MODE_CODE_AMIN: mode = MODE_CODE_AHOUR;
              MODE_CODE_HOUR: begin
                cmd = CMD_SET_TIME;
                cmd_bcd = edit_bcd[13:0];
                clk_ok = 1'b1;
                clk_now = cmd_bcd;
                mode = MODE_CODE_NORMAL;
              end
              default: begin
                cmd = CMD_SET_ALARM;
                cmd_bcd = edit_bcd[13:0];
                mode = MODE_CODE_NORMAL;
              end
            endcase
            idle_ticks = '0;
          end
          if (rise[3] || idle_ticks >= idle_limit)
            mode = (time_field && !clk_ok) ? MODE_CODE_UNSET : MODE_CODE_NORMAL;
        end
      end

      if (t.alarm_fired) ringing = 1'b1;

      // seconds dot
      blink_ticks = (blink_ticks == 8'hFF) ? blink_ticks : blink_ticks + 8'd1;
      if (blink_ticks >= blink_half) begin
        blink_ticks = '0;
        blink_on = ~blink_on;
      end

      if (cmd == CMD_ALARM_ON) alarm_dot = 1'b1;
      if (cmd == CMD_ALARM_OFF) alarm_dot = 1'b0;

      want = '0;
      want.command = cmd;
      want.command_time_bcd = cmd_bcd;
      want.buzzer_on = ringing;
      want.mode = mode;
      case (mode)
        MODE_CODE_UNSET:                 want.flash_mask = FLASH_ALL;
        MODE_CODE_MIN, MODE_CODE_AMIN:   want.flash_mask = FLASH_MINUTES;
        MODE_CODE_HOUR, MODE_CODE_AHOUR: want.flash_mask = FLASH_HOURS;
        default:                         want.flash_mask = 4'b0000;
      endcase
      if (mode == MODE_CODE_NORMAL || mode == MODE_CODE_UNSET) begin
        want.shown_time_bcd = clk_ok ? clk_now : 14'h0000;
        want.dot_mask = (blink_on ? DOT_SECONDS : 4'b0000) | (alarm_dot ? DOT_ALARM : 4'b0000);
      end else begin
        want.shown_time_bcd = edit_bcd[13:0];
        want.dot_mask = (mode == MODE_CODE_AMIN || mode == MODE_CODE_AHOUR) ? DOTS_ALL : 4'b0000;
      end
      expected_q.push_back(want);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: result %h arrived with nothing expected", $time, got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t ns: expected cmd %0d t %h buz %0d shown %h flash %h dots %h mode %0d",
                 $time, want.command, want.command_time_bcd, want.buzzer_on,
                 want.shown_time_bcd, want.flash_mask, want.dot_mask, want.mode);
        $display("%0t ns: actual   cmd %0d t %h buz %0d shown %h flash %h dots %h mode %0d",
                 $time, got.command, got.command_time_bcd, got.buzzer_on,
                 got.shown_time_bcd, got.flash_mask, got.dot_mask, got.mode);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;

  tick_scoreboard sb;
  int          ticks_sent;
  logic        tx_steady;
  logic        rx_steady;
  logic        hold_off_req;
  logic        ctx_valid;
  logic [13:0] ctx_time;
  logic [13:0] ctx_alarm;
  logic        ctx_alarm_en;

  alarm_clock_setting_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Note accepted ticks and check accepted results on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_tick(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      out_ready <= rx_steady || ($urandom_range(0, 99) >= 11);
      @(posedge clk);
    end
  end

  function automatic in_t make_tick(input logic [5:0] keys, input logic fired);
    in_t t;
    t = '0;
    {t.key_f1, t.key_f2, t.key_down, t.key_up, t.key_accept, t.key_cancel} = keys;
    t.alarm_fired = fired;
    t.clock_valid = ctx_valid;
    t.clock_time_bcd = ctx_time;
    t.alarm_time_bcd = ctx_alarm;
    t.alarm_is_enabled = ctx_alarm_en;
    return t;
  endfunction

  function automatic logic random_fire();
    return $urandom_range(0, 49) == 0;
  endfunction

  function automatic logic [13:0] random_hhmm();
    logic [31:0] h, m, ht, hu, mt, mu, raw;
    raw = $urandom();
    if ($urandom_range(0, 9) == 0) return raw[13:0];
    h = $urandom_range(0, 23);
    m = $urandom_range(0, 59);
    ht = h / 10;
    hu = h % 10;
    mt = m / 10;
    mu = m % 10;
    return {ht[1:0], hu[3:0], mt[3:0], mu[3:0]};
  endfunction

  function automatic logic [5:0] pick_tap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return KEY_UP;
    if (r < 70) return KEY_DOWN;
    if (r < 88) return KEY_ACCEPT;
    if (r < 95) return KEY_CANCEL;
    return KEY_ACCEPT | KEY_CANCEL;
  endfunction

  // Offer one tick and hold it until the block takes it; valid stays high after
  task automatic send_tick(input in_t t);
    if (!tx_steady && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Drain the pipeline, then write all three registers back to back
  task automatic apply_settings(input logic [15:0] lp, input logic [15:0] idle,
                                input logic [7:0] blink);
    in_valid <= 1'b0;
    // let the last accepted tick reach the scoreboard before counting
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_LONG_PRESS;
    cfg_wdata <= lp;
    @(posedge clk);
    cfg_idx <= CFG_IDLE_TIMEOUT;
    cfg_wdata <= idle;
    @(posedge clk);
    cfg_idx <= CFG_BLINK_HALF;
    cfg_wdata <= {8'h00, blink};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(CFG_LONG_PRESS, lp);
    sb.set_register(CFG_IDLE_TIMEOUT, idle);
    sb.set_register(CFG_BLINK_HALF, {8'h00, blink});
  endtask

  // One user session: long press, then key taps, sometimes a quiet stretch
  task automatic run_session();
    int          lp, hold, entry_at, quiet, k, r;
    logic [5:0]  grip, tap;
    logic [31:0] raw;
    lp = sb.long_press;
    if ($urandom_range(0, 9) < 7) begin
      ctx_valid = ($urandom_range(0, 9) != 0);
      ctx_time = random_hhmm();
      ctx_alarm = random_hhmm();
      raw = $urandom();
      ctx_alarm_en = raw[0];
    end
    r = $urandom_range(0, 19);
    if (r == 0) grip = KEY_F1 | KEY_F2;
    else if (r < 8) grip = KEY_F2;
    else grip = KEY_F1;
    if (lp <= 60) begin
      hold = ((lp == 0) ? 1 : lp) + $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) hold = $urandom_range(1, (lp == 0) ? 1 : lp);
    end else begin
      hold = $urandom_range(1, 40);
    end
    entry_at = (lp == 0) ? 0 : lp - 1;
    for (k = 0; k < hold; k++) begin
      tap = KEYS_NONE;
      if (k == entry_at && $urandom_range(0, 9) < 4) tap = pick_tap();
      send_tick(make_tick(grip | tap, random_fire()));
    end
    repeat ($urandom_range(0, 10)) begin
      tap = pick_tap();
      repeat ($urandom_range(1, 2)) send_tick(make_tick(tap, random_fire()));
      repeat ($urandom_range(0, 2)) send_tick(make_tick(KEYS_NONE, random_fire()));
    end
    if ($urandom_range(0, 3) == 0) begin
      quiet = (sb.idle_limit <= 60) ? $urandom_range(0, sb.idle_limit + 2)
                                    : $urandom_range(0, 20);
      repeat (quiet) send_tick(make_tick(KEYS_NONE, random_fire()));
    end
    send_tick(make_tick(KEYS_NONE, 1'b0));
  endtask

  // Mostly well-formed sessions, some bursts of raw noise
  task automatic run_phase(input int n_ticks);
    int          first;
    logic [63:0] bits;
    first = ticks_sent;
    while (ticks_sent - first < n_ticks) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 4)) begin
          bits = {$urandom(), $urandom()};
          send_tick(bits[$bits(in_t)-1:0]);
        end
      end else begin
        run_session();
      end
    end
  endtask

  initial begin
    sb = new();
    ticks_sent = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    ctx_valid = 1'b0;
    ctx_time = '0;
    ctx_alarm = '0;
    ctx_alarm_en = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: alarm keys and ringing with reset settings
    send_tick(make_tick(KEYS_NONE, 1'b0));
    ctx_valid = 1'b1;
    ctx_time = 14'h3FFF;
    ctx_alarm = 14'h0000;
    ctx_alarm_en = 1'b1;
    send_tick(make_tick(KEYS_NONE, 1'b0));
    send_tick(make_tick(KEY_ACCEPT, 1'b0));
    send_tick(make_tick(KEY_CANCEL, 1'b0));
    send_tick(make_tick(KEYS_NONE, 1'b0));
    send_tick(make_tick(KEY_ACCEPT | KEY_CANCEL, 1'b0));
    send_tick(make_tick(KEYS_NONE, 1'b1));
    send_tick(make_tick(KEY_ACCEPT, 1'b0));
    send_tick(make_tick(KEYS_NONE, 1'b1));
    send_tick(make_tick(KEY_CANCEL, 1'b0));

    // Directed: editing with a one-tick long press
    apply_settings(16'd1, 16'd3, 8'd1);
    ctx_time = 14'h2359;
    ctx_alarm = 14'h3FFF;
    ctx_alarm_en = 1'b0;
    send_tick(make_tick(KEY_F1 | KEY_UP, 1'b0));
    send_tick(make_tick(KEY_F1, 1'b0));
    send_tick(make_tick(KEY_DOWN, 1'b0));
    send_tick(make_tick(KEYS_NONE, 1'b0));
    send_tick(make_tick(KEY_ACCEPT, 1'b0));
    send_tick(make_tick(KEY_UP, 1'b0));
    ctx_valid = 1'b0;
    send_tick(make_tick(KEY_ACCEPT, 1'b0));
    send_tick(make_tick(KEY_F1 | KEY_F2, 1'b0));
    send_tick(make_tick(KEY_CANCEL, 1'b0));
    ctx_valid = 1'b1;
    send_tick(make_tick(KEY_F1, 1'b0));
    send_tick(make_tick(KEY_F1 | KEY_CANCEL, 1'b0));
    send_tick(make_tick(KEY_F2, 1'b0));
    send_tick(make_tick(KEY_DOWN, 1'b0));
    send_tick(make_tick(KEY_ACCEPT, 1'b0));
    send_tick(make_tick(KEY_UP, 1'b0));
    send_tick(make_tick(KEY_ACCEPT, 1'b0));

    // Random phases over several settings
    apply_settings(16'd30, 16'd300, 8'd5);
    run_phase(300);
    apply_settings(16'd1, 16'd1, 8'd1);
    run_phase(150);
    apply_settings(16'd0, 16'd0, 8'd0);
    run_phase(100);
    apply_settings(16'd3, 16'd20, 8'd7);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_phase(300);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    apply_settings(16'hFFFF, 16'hFFFF, 8'hFF);
    run_phase(100);
    apply_settings(16'd2, 16'd8, 8'd2);
    hold_off_req = 1'b1;
    run_phase(400);

    // Wait out the pipeline and watch for stray results
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/acsc_pkg.sv
hw/rtl/acsc_cfg_regs.sv
hw/rtl/acsc_core.sv
hw/rtl/alarm_clock_setting_controller.sv
hw/rtl/acsc_checker.sv
dv/alarm_clock_setting_controller_test.sv
